[src/srq_pkg.sv]
// Package for the sequence reorder queue.
// Holds the shared types, codes and default sizes; depends on nothing.
`default_nettype none
package srq_pkg;

  localparam int DATA_W         = 32;
  localparam int AVG_W          = 40;
  localparam int OCC_W          = 5;
  localparam int DEF_DEPTH      = 16;
  localparam int DEF_SEQ_BITS   = 32;
  localparam int DEF_FRAC_BITS  = 8;

  typedef enum logic [1:0] {
    MODE_APPEND    = 2'd0,
    MODE_SORTED    = 2'd1,
    MODE_POP       = 2'd2,
    MODE_POP_ORDER = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_ORDER = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PREP,
    ST_DIV
  } state_t;

  // One classified request as handed from the front to the back.
  typedef struct packed {
    mode_t              mode;
    logic [DATA_W-1:0]  seq;
    logic [DATA_W-1:0]  payload;
    logic [DATA_W-1:0]  arrival;
    logic [DATA_W-1:0]  want;
  } item_t;

  // One stored queue entry.
  typedef struct packed {
    logic [DATA_W-1:0] seq;
    logic [DATA_W-1:0] payload;
    logic [DATA_W-1:0] gap;
  } slot_t;

  // One result.
  typedef struct packed {
    status_t            status;
    logic               popped_valid;
    logic [DATA_W-1:0]  popped_seq;
    logic [DATA_W-1:0]  popped_payload;
    logic [DATA_W-1:0]  popped_gap;
    logic [OCC_W-1:0]   occupancy;
    logic               queue_empty;
    logic [AVG_W-1:0]   average_gap;
  } result_t;

endpackage
`default_nettype wire

[src/srq_front.sv]
// Front end of the sequence reorder queue: accepts requests, masks the
// sequence fields and holds them in a two-entry queue. Depends on srq_pkg.
`default_nettype none
module srq_front #(
  parameter int SEQ_BITS = srq_pkg::DEF_SEQ_BITS
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire  [1:0]                    in_mode,
  input  wire  [srq_pkg::DATA_W-1:0]    in_entry_seq,
  input  wire  [srq_pkg::DATA_W-1:0]    in_entry_payload,
  input  wire  [srq_pkg::DATA_W-1:0]    in_arrival_time,
  input  wire  [srq_pkg::DATA_W-1:0]    in_previous_seq,
  output logic                          item_valid,
  output srq_pkg::item_t                item,
  input  wire                           item_pop
);

  localparam logic [srq_pkg::DATA_W-1:0] SEQ_MASK =
    srq_pkg::DATA_W'((64'd1 << SEQ_BITS) - 64'd1);

  srq_pkg::item_t fifo_r [2];
  logic           wr_r, wr_nxt;
  logic           rd_r, rd_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  srq_pkg::item_t cls;
  logic           push, pop;

  // Classify the incoming request: mask sequences and form the wanted next one.
  always_comb begin
    cls.mode    = srq_pkg::mode_t'(in_mode);
    cls.seq     = in_entry_seq & SEQ_MASK;
    cls.payload = in_entry_payload;
    cls.arrival = in_arrival_time;
    cls.want    = ((in_previous_seq & SEQ_MASK) + srq_pkg::DATA_W'(1)) & SEQ_MASK;
  end

  assign in_stall   = (cnt_r == 2'd2);
  assign push       = in_valid && !in_stall;
  assign item_valid = (cnt_r != 2'd0);
  assign pop        = item_pop && item_valid;
  assign item       = fifo_r[rd_r];

  // Pointer and fill count update.
  always_comb begin
    wr_nxt  = push ? !wr_r : wr_r;
    rd_nxt  = pop ? !rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_r] <= cls;
    end
  end

endmodule
`default_nettype wire

[src/srq_divider.sv]
// Restoring divider, one quotient bit per cycle, for the running average.
// Depends on srq_pkg.
`default_nettype none
module srq_divider #(
  parameter int NW = 41
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  input  wire  [NW-1:0]               dividend,
  input  wire  [srq_pkg::DATA_W-1:0]  divisor,
  output logic                        busy,
  output logic [NW-1:0]               quotient
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [srq_pkg::DATA_W:0]   rem_r, rem_nxt;
  logic [NW-1:0]              q_r, q_nxt;
  logic [srq_pkg::DATA_W-1:0] d_r;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic [srq_pkg::DATA_W:0]   rem_sh;
  logic                       ge;

  // One step of shift, compare and subtract.
  always_comb begin
    rem_sh   = {rem_r[srq_pkg::DATA_W-1:0], q_r[NW-1]};
    ge       = rem_sh >= {1'b0, d_r};
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = dividend;
      cnt_nxt  = CNT_W'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? (rem_sh - {1'b0, d_r}) : rem_sh;
      q_nxt    = {q_r[NW-2:0], ge};
      cnt_nxt  = cnt_r - CNT_W'(1);
      busy_nxt = (cnt_r != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (start) begin
      d_r <= divisor;
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule
`default_nettype wire

[src/srq_back.sv]
// Back end of the sequence reorder queue: entry store, sorted scan, gap
// average and result register. Depends on srq_pkg and srq_divider.
`default_nettype none
module srq_back #(
  parameter int QUEUE_DEPTH   = srq_pkg::DEF_DEPTH,
  parameter int FRACTION_BITS = srq_pkg::DEF_FRAC_BITS
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              item_valid,
  input  srq_pkg::item_t   item,
  output logic             item_pop,
  output logic             out_valid,
  input  wire              out_stall,
  output srq_pkg::result_t result
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int TW = srq_pkg::DATA_W + FRACTION_BITS;
  localparam int DW = (TW > srq_pkg::AVG_W) ? TW : srq_pkg::AVG_W;
  localparam int NW = DW + 1;
  localparam logic [srq_pkg::AVG_W-1:0]  AVG_MAX   = {srq_pkg::AVG_W{1'b1}};
  localparam logic [srq_pkg::DATA_W-1:0] TOTAL_MAX = {srq_pkg::DATA_W{1'b1}};

  srq_pkg::slot_t   slot_r [QUEUE_DEPTH];
  srq_pkg::state_t  state_r, state_nxt;
  srq_pkg::item_t   cur_r, cur_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    pos_r, pos_nxt;
  logic [srq_pkg::DATA_W-1:0] last_r, last_nxt;
  logic [srq_pkg::DATA_W-1:0] total_r, total_nxt;
  logic [srq_pkg::DATA_W-1:0] gap_r, gap_nxt;
  logic [srq_pkg::AVG_W-1:0]  avg_r, avg_nxt;
  logic             up_r, up_nxt;
  logic             out_valid_r, out_valid_nxt;
  srq_pkg::result_t res_r, res_nxt;

  logic             out_free;
  logic             do_ins, do_pop;
  logic [CW-1:0]    ins_pos;
  srq_pkg::slot_t   ins_slot;
  logic [srq_pkg::DATA_W-1:0] gap_calc;
  logic [DW-1:0]    target, avg_ext;
  logic [NW-1:0]    dividend;
  logic             div_start, div_busy;
  logic [NW-1:0]    quot;
  logic [NW:0]      avg_sum;
  srq_pkg::slot_t   scan_slot;

  srq_divider #(.NW(NW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (total_r),
    .busy     (div_busy),
    .quotient (quot)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign scan_slot = slot_r[pos_r[IW-1:0]];

  // Gap since the previous sorted arrival; zero on a first or earlier arrival.
  assign gap_calc = ((last_r == '0) || (cur_r.arrival < last_r)) ? '0 :
                    (cur_r.arrival - last_r);

  // Dividend for the average step: rounded down going up, rounded up going down.
  always_comb begin
    target  = DW'(gap_r) << FRACTION_BITS;
    avg_ext = DW'(avg_r);
    up_nxt  = up_r;
    if (target >= avg_ext) begin
      dividend = NW'(target - avg_ext);
    end else begin
      dividend = NW'(avg_ext - target) + NW'(total_r) - NW'(1);
    end
    if (state_r == srq_pkg::ST_PREP) begin
      up_nxt = (target >= avg_ext);
    end
  end

  assign avg_sum = up_r ? ((NW+1)'(avg_r) + (NW+1)'(quot)) :
                          ((NW+1)'(avg_r) - (NW+1)'(quot));

  // Sequencer: next state, store operations and result.
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    pos_nxt       = pos_r;
    last_nxt      = last_r;
    total_nxt     = total_r;
    gap_nxt       = gap_r;
    avg_nxt       = avg_r;
    out_valid_nxt = out_valid_r && out_stall;
    res_nxt       = res_r;
    item_pop      = 1'b0;
    do_ins        = 1'b0;
    do_pop        = 1'b0;
    ins_pos       = count_r;
    ins_slot      = '{seq: cur_r.seq, payload: cur_r.payload, gap: '0};
    div_start     = 1'b0;
    unique case (state_r)
      srq_pkg::ST_IDLE: begin
        if (item_valid && out_free) begin
          item_pop            = 1'b1;
          cur_nxt             = item;
          out_valid_nxt       = 1'b1;
          res_nxt             = '0;
          res_nxt.status      = srq_pkg::STAT_OK;
          res_nxt.average_gap = avg_r;
          unique case (item.mode)
            srq_pkg::MODE_APPEND, srq_pkg::MODE_SORTED: begin
              if (count_r == CW'(QUEUE_DEPTH)) begin
                res_nxt.status = srq_pkg::STAT_FULL;
              end else if (item.mode == srq_pkg::MODE_APPEND) begin
                do_ins   = 1'b1;
                ins_slot = '{seq: item.seq, payload: item.payload, gap: '0};
              end else begin
                out_valid_nxt = out_valid_r && out_stall;
                pos_nxt       = '0;
                state_nxt     = srq_pkg::ST_SCAN;
              end
            end
            srq_pkg::MODE_POP, srq_pkg::MODE_POP_ORDER: begin
              if (count_r == '0) begin
                res_nxt.status = srq_pkg::STAT_EMPTY;
              end else if (item.mode == srq_pkg::MODE_POP || slot_r[0].seq == item.want) begin
                do_pop                 = 1'b1;
                res_nxt.popped_valid   = 1'b1;
                res_nxt.popped_seq     = slot_r[0].seq;
                res_nxt.popped_payload = slot_r[0].payload;
                res_nxt.popped_gap     = slot_r[0].gap;
              end else begin
                res_nxt.status = srq_pkg::STAT_ORDER;
              end
            end
            default: ;
          endcase
        end
      end
      srq_pkg::ST_SCAN: begin
        if ((pos_r < count_r) && (scan_slot.seq <= cur_r.seq)) begin
          pos_nxt = pos_r + CW'(1);
        end else begin
          do_ins    = 1'b1;
          ins_pos   = pos_r;
          ins_slot  = '{seq: cur_r.seq, payload: cur_r.payload, gap: gap_calc};
          gap_nxt   = gap_calc;
          last_nxt  = cur_r.arrival;
          total_nxt = (total_r == TOTAL_MAX) ? total_r : (total_r + srq_pkg::DATA_W'(1));
          state_nxt = srq_pkg::ST_PREP;
        end
      end
      srq_pkg::ST_PREP: begin
        div_start = 1'b1;
        state_nxt = srq_pkg::ST_DIV;
      end
      srq_pkg::ST_DIV: begin
        if (!div_busy && out_free) begin
          avg_nxt = (avg_sum > (NW+1)'(AVG_MAX)) ? AVG_MAX : avg_sum[srq_pkg::AVG_W-1:0];
          out_valid_nxt       = 1'b1;
          res_nxt             = '0;
          res_nxt.status      = srq_pkg::STAT_OK;
          res_nxt.average_gap = avg_nxt;
          state_nxt           = srq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = srq_pkg::ST_IDLE;
    endcase
    count_nxt = count_r + CW'(do_ins) - CW'(do_pop);
    if (state_r == srq_pkg::ST_IDLE || state_r == srq_pkg::ST_DIV) begin
      res_nxt.occupancy   = out_valid_nxt && !(out_valid_r && out_stall) ?
                            srq_pkg::OCC_W'(count_nxt) : res_r.occupancy;
      res_nxt.queue_empty = out_valid_nxt && !(out_valid_r && out_stall) ?
                            (count_nxt == '0) : res_r.queue_empty;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srq_pkg::ST_IDLE;
      count_r     <= '0;
      last_r      <= '0;
      total_r     <= '0;
      avg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      last_r      <= last_nxt;
      total_r     <= total_nxt;
      avg_r       <= avg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    pos_r <= pos_nxt;
    gap_r <= gap_nxt;
    up_r  <= up_nxt;
    res_r <= res_nxt;
  end

  // Entry store: shift towards the head on a pop, open a gap on an insert.
  always_ff @(posedge clk) begin
    if (do_pop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        slot_r[i] <= slot_r[i+1];
      end
    end else if (do_ins) begin
      if (ins_pos == '0) begin
        slot_r[0] <= ins_slot;
      end
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
        if (CW'(i) == ins_pos) begin
          slot_r[i] <= ins_slot;
        end else if ((CW'(i) > ins_pos) && (CW'(i) <= count_r)) begin
          slot_r[i] <= slot_r[i-1];
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign result    = res_r;

endmodule
`default_nettype wire

[src/sequence_reorder_queue_unit.sv]
// Sequence reorder queue, top level. Append, pop and in-order pop requests
// are answered from the back end's idle state; a sorted insert first scans
// the stored entries for its place, then runs the serial average divider
// before its result is registered.
// Requests are handled one at a time by the back end; a two-entry front queue
// takes new requests meanwhile. Synchronous active-low reset empties the queue
// and clears the average; the entry store itself is not cleared.
// Depends on srq_pkg, srq_front, srq_back.
`default_nettype none
module sequence_reorder_queue_unit #(
  parameter int QUEUE_DEPTH   = srq_pkg::DEF_DEPTH,
  parameter int SEQ_BITS      = srq_pkg::DEF_SEQ_BITS,
  parameter int FRACTION_BITS = srq_pkg::DEF_FRAC_BITS
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [1:0]                   in_mode,
  input  wire  [srq_pkg::DATA_W-1:0]   in_entry_seq,
  input  wire  [srq_pkg::DATA_W-1:0]   in_entry_payload,
  input  wire  [srq_pkg::DATA_W-1:0]   in_arrival_time,
  input  wire  [srq_pkg::DATA_W-1:0]   in_previous_seq,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [1:0]                   out_status,
  output logic                         out_popped_valid,
  output logic [srq_pkg::DATA_W-1:0]   out_popped_seq,
  output logic [srq_pkg::DATA_W-1:0]   out_popped_payload,
  output logic [srq_pkg::DATA_W-1:0]   out_popped_gap,
  output logic [srq_pkg::OCC_W-1:0]    out_occupancy,
  output logic                         out_queue_empty,
  output logic [srq_pkg::AVG_W-1:0]    out_average_gap
);

  logic             item_valid;
  logic             item_pop;
  srq_pkg::item_t   item;
  srq_pkg::result_t result;

  srq_front #(.SEQ_BITS(SEQ_BITS)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_entry_seq     (in_entry_seq),
    .in_entry_payload (in_entry_payload),
    .in_arrival_time  (in_arrival_time),
    .in_previous_seq  (in_previous_seq),
    .item_valid       (item_valid),
    .item             (item),
    .item_pop         (item_pop)
  );

  srq_back #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result     (result)
  );

  // Unpack the result register onto the output ports.
  assign out_status         = result.status;
  assign out_popped_valid   = result.popped_valid;
  assign out_popped_seq     = result.popped_seq;
  assign out_popped_payload = result.popped_payload;
  assign out_popped_gap     = result.popped_gap;
  assign out_occupancy      = result.occupancy;
  assign out_queue_empty    = result.queue_empty;
  assign out_average_gap    = result.average_gap;

endmodule
`default_nettype wire

[tb/srq_checker.sv]
// Checker for the sequence reorder queue: watches both channels, predicts each
// result from its own model of the queue and compares field by field.
// Depends on srq_pkg.
`timescale 1ns / 1ps
module srq_checker (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  input  wire                        in_stall,
  input  wire  [1:0]                 in_mode,
  input  wire  [31:0]                in_entry_seq,
  input  wire  [31:0]                in_entry_payload,
  input  wire  [31:0]                in_arrival_time,
  input  wire  [31:0]                in_previous_seq,
  input  wire                        out_valid,
  input  wire                        out_stall,
  input  wire  [1:0]                 out_status,
  input  wire                        out_popped_valid,
  input  wire  [31:0]                out_popped_seq,
  input  wire  [31:0]                out_popped_payload,
  input  wire  [31:0]                out_popped_gap,
  input  wire  [4:0]                 out_occupancy,
  input  wire                        out_queue_empty,
  input  wire  [39:0]                out_average_gap,
  output int                         fail_count,
  output int                         pending_results,
  output int                         results_seen
);

  localparam int DEPTH = 16;
  localparam logic [39:0] AVG_LIMIT = 40'hFF_FFFF_FFFF;

  // Model state of the queue.
  logic [31:0] q_seq [DEPTH];
  logic [31:0] q_pay [DEPTH];
  logic [31:0] q_gap [DEPTH];
  int          q_count;
  logic [31:0] last_arr;
  logic [39:0] avg_gap;
  logic [31:0] sorted_n;

  srq_pkg::result_t expected_results[$];

  assign pending_results = expected_results.size();

  // Shift entries up from pos and write the new one there.
  function automatic void store_entry(int pos, logic [31:0] s, logic [31:0] p,
                                      logic [31:0] g);
    for (int i = q_count; i > pos; i--) begin
      q_seq[i] = q_seq[i-1];
      q_pay[i] = q_pay[i-1];
      q_gap[i] = q_gap[i-1];
    end
    q_seq[pos] = s;
    q_pay[pos] = p;
    q_gap[pos] = g;
    q_count++;
  endfunction

  // Remove the head into the result.
  function automatic void take_head(ref srq_pkg::result_t r);
    r.popped_valid   = 1'b1;
    r.popped_seq     = q_seq[0];
    r.popped_payload = q_pay[0];
    r.popped_gap     = q_gap[0];
    for (int i = 1; i < q_count; i++) begin
      q_seq[i-1] = q_seq[i];
      q_pay[i-1] = q_pay[i];
      q_gap[i-1] = q_gap[i];
    end
    q_count--;
  endfunction

  // Running average, the exact new value rounded down.
  function automatic void fold_gap(logic [31:0] g);
    logic [63:0] n, tgt, res, cur;
    if (sorted_n != 32'hFFFF_FFFF) sorted_n++;
    n   = {32'd0, sorted_n};
    tgt = {32'd0, g} << 8;
    cur = {24'd0, avg_gap};
    if (tgt >= cur) res = cur + (tgt - cur) / n;
    else res = cur - ((cur - tgt) + n - 1) / n;
    if (res > {24'd0, AVG_LIMIT}) res = {24'd0, AVG_LIMIT};
    avg_gap = res[39:0];
  endfunction

  function automatic srq_pkg::result_t predict_queue_step(srq_pkg::mode_t m,
      logic [31:0] s, logic [31:0] p, logic [31:0] arr, logic [31:0] prev);
    srq_pkg::result_t r;
    int pos;
    logic [31:0] g;
    r = '0;
    r.status = srq_pkg::STAT_OK;
    if (m == srq_pkg::MODE_APPEND || m == srq_pkg::MODE_SORTED) begin
      if (q_count >= DEPTH) r.status = srq_pkg::STAT_FULL;
      else if (m == srq_pkg::MODE_APPEND) store_entry(q_count, s, p, 32'd0);
      else begin
        pos = 0;
        while (pos < q_count && q_seq[pos] <= s) pos++;
        g = (last_arr == 0 || arr < last_arr) ? 32'd0 : arr - last_arr;
        store_entry(pos, s, p, g);
        last_arr = arr;
        fold_gap(g);
      end
    end else begin
      if (q_count == 0) r.status = srq_pkg::STAT_EMPTY;
      else if (m == srq_pkg::MODE_POP) take_head(r);
      else if (q_seq[0] == prev + 32'd1) take_head(r);
      else r.status = srq_pkg::STAT_ORDER;
    end
    r.occupancy   = q_count[4:0];
    r.queue_empty = (q_count == 0);
    r.average_gap = avg_gap;
    return r;
  endfunction

  // Watch both channels at each edge.
  always @(posedge clk) begin
    srq_pkg::result_t e;
    if (!rst_n) begin
      q_count <= 0;
      last_arr <= '0;
      avg_gap <= '0;
      sorted_n <= '0;
      fail_count <= 0;
      results_seen <= 0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_results.pop_front();
          if ({out_status, out_popped_valid, out_popped_seq, out_popped_payload,
               out_popped_gap, out_occupancy, out_queue_empty, out_average_gap}
              != e) begin
            fail_count <= fail_count + 1;
            if (out_status != e.status)
              $error("status: expected %0d, got %0d", e.status, out_status);
            if (out_popped_valid != e.popped_valid)
              $error("popped_valid: expected %0d, got %0d", e.popped_valid,
                     out_popped_valid);
            if (out_popped_seq != e.popped_seq)
              $error("popped_seq: expected %0h, got %0h", e.popped_seq,
                     out_popped_seq);
            if (out_popped_payload != e.popped_payload)
              $error("popped_payload: expected %0h, got %0h", e.popped_payload,
                     out_popped_payload);
            if (out_popped_gap != e.popped_gap)
              $error("popped_gap: expected %0h, got %0h", e.popped_gap,
                     out_popped_gap);
            if (out_occupancy != e.occupancy)
              $error("occupancy: expected %0d, got %0d", e.occupancy,
                     out_occupancy);
            if (out_queue_empty != e.queue_empty)
              $error("queue_empty: expected %0d, got %0d", e.queue_empty,
                     out_queue_empty);
            if (out_average_gap != e.average_gap)
              $error("average_gap: expected %0h, got %0h", e.average_gap,
                     out_average_gap);
          end
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(predict_queue_step(srq_pkg::mode_t'(in_mode),
            in_entry_seq, in_entry_payload, in_arrival_time, in_previous_seq));
    end
  end
endmodule

[tb/tb.sv]
// Top of the sequence reorder queue testbench: clock, reset, request stimulus
// with bursty gaps and a random result stall, and the verdict.
// Depends on srq_pkg, srq_checker and the block itself.
`timescale 1ns / 1ps
module tb;

  localparam int CYCLE_LIMIT = 1_500_000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_mode;
  logic [31:0] in_entry_seq, in_entry_payload, in_arrival_time, in_previous_seq;
  logic        out_valid, out_stall;
  logic [1:0]  out_status;
  logic        out_popped_valid;
  logic [31:0] out_popped_seq, out_popped_payload, out_popped_gap;
  logic [4:0]  out_occupancy;
  logic        out_queue_empty;
  logic [39:0] out_average_gap;
  int          fail_count, pending_results, results_seen;
  int          cycles;
  int          sent;
  int          stall_mode;
  logic [31:0] seq_base, arr_clock;

  sequence_reorder_queue_unit dut (.*);
  srq_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter guarding against a hang.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Result stall: phases of no stall, light stall and heavy stall.
  initial begin
    out_stall = 1'b0;
    stall_mode = 0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Present one request and hold it until accepted.
  task automatic send_request(srq_pkg::mode_t m, logic [31:0] s, logic [31:0] p,
                              logic [31:0] arr, logic [31:0] prev);
    in_valid         <= 1'b1;
    in_mode          <= m;
    in_entry_seq     <= s;
    in_entry_payload <= p;
    in_arrival_time  <= arr;
    in_previous_seq  <= prev;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic pause_sender(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stop sending and wait until the checker holds no outstanding result.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  // Random request, weighted towards well-formed in-order traffic.
  task automatic random_request();
    int pick;
    logic [31:0] s;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      s = seq_base + $urandom_range(0, 20);
      arr_clock = arr_clock + $urandom_range(0, 3000);
      send_request(srq_pkg::MODE_SORTED, s, $urandom, arr_clock, 32'd0);
    end else if (pick < 40) begin
      send_request(srq_pkg::MODE_SORTED, $urandom, $urandom, $urandom, $urandom);
    end else if (pick < 50) begin
      send_request(srq_pkg::MODE_APPEND, ($urandom_range(0, 1) ? $urandom : seq_base),
                   $urandom, $urandom, $urandom);
    end else if (pick < 65) begin
      send_request(srq_pkg::MODE_POP, $urandom, $urandom, $urandom, $urandom);
    end else if (pick < 90) begin
      send_request(srq_pkg::MODE_POP_ORDER, $urandom, $urandom, $urandom,
                   seq_base + $urandom_range(0, 20) - 1);
    end else begin
      send_request(srq_pkg::MODE_POP_ORDER, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    in_valid = 1'b0;
    in_mode = srq_pkg::MODE_APPEND;
    in_entry_seq = '0;
    in_entry_payload = '0;
    in_arrival_time = '0;
    in_previous_seq = '0;
    rst_n = 1'b0;
    sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pops, first arrival, earlier arrival, extremes.
    send_request(srq_pkg::MODE_POP, '0, '0, '0, '0);
    send_request(srq_pkg::MODE_POP_ORDER, '0, '0, '0, 32'hFFFF_FFFF);
    send_request(srq_pkg::MODE_SORTED, 32'd5, 32'hFFFF_FFFF, 32'd0, '0);
    send_request(srq_pkg::MODE_SORTED, 32'd3, 32'h0, 32'd100, '0);
    send_request(srq_pkg::MODE_SORTED, 32'd5, 32'h1, 32'd40, '0);
    send_request(srq_pkg::MODE_SORTED, 32'hFFFF_FFFF, 32'h2, 32'hFFFF_FFFF, '0);
    send_request(srq_pkg::MODE_SORTED, 32'd0, 32'h3, 32'd1, '0);
    send_request(srq_pkg::MODE_APPEND, 32'd1, 32'hA5A5_5A5A, 32'hFFFF_FFFF, '0);
    send_request(srq_pkg::MODE_POP_ORDER, '0, '0, '0, 32'hFFFF_FFFF);
    send_request(srq_pkg::MODE_POP_ORDER, '0, '0, '0, 32'd7);
    send_request(srq_pkg::MODE_POP_ORDER, '0, '0, '0, 32'd2);
    for (int i = 0; i < 12; i++)
      send_request(srq_pkg::MODE_APPEND, $urandom, $urandom, '0, '0);
    send_request(srq_pkg::MODE_APPEND, 32'd9, 32'd9, '0, '0);
    send_request(srq_pkg::MODE_SORTED, 32'd9, 32'd9, 32'd500, '0);
    for (int i = 0; i < 17; i++)
      send_request(srq_pkg::MODE_POP, '0, '0, '0, '0);

    // Hold off until every result is back.
    drain_results();

    // Random part in bursts with gaps.
    seq_base = $urandom;
    arr_clock = $urandom_range(1, 1000);
    while (sent < 2100) begin
      repeat ($urandom_range(1, 30)) begin
        random_request();
        if ($urandom_range(0, 15) == 0) seq_base = seq_base + $urandom_range(1, 8);
      end
      if ($urandom_range(0, 40) == 0) seq_base = $urandom;
      if ($urandom_range(0, 30) == 0) begin
        drain_results();
      end else begin
        pause_sender($urandom_range(0, 60));
      end
    end

    drain_results();
    repeat (100) @(posedge clk);
    $display("Sent %0d requests covering all four modes, full and empty queue;",
             sent);
    $display("%0d results compared against the prediction.", results_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
